// ===== hdl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Types, character codes, token kinds and keyword table shared by the SQL
// token lexer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

   // field widths
   localparam int POS_BITS      = 16;
   localparam int LEN_BITS      = 12;
   localparam int MAX_TOKEN_LEN = 4096;
   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN - 1);

   // keyword buffer: six upper-cased characters
   localparam int KW_CHARS = 6;
   localparam int KW_BITS  = KW_CHARS * 8;
   localparam int KW_COUNT = 8;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = PTR_BITS + 1;

   // token kinds
   typedef enum logic [4:0] {
      KIND_STAR    = 5'd0,
      KIND_COMMA   = 5'd1,
      KIND_SEMI    = 5'd2,
      KIND_LPAREN  = 5'd3,
      KIND_RPAREN  = 5'd4,
      KIND_EQUAL   = 5'd5,
      KIND_END     = 5'd6,
      KIND_STRING  = 5'd7,
      KIND_NUMBER  = 5'd8,
      KIND_IDENT   = 5'd9,
      KIND_ILLEGAL = 5'd10,
      KIND_SELECT  = 5'd11,
      KIND_FROM    = 5'd12,
      KIND_WHERE   = 5'd13,
      KIND_INSERT  = 5'd14,
      KIND_INTO    = 5'd15,
      KIND_VALUES  = 5'd16,
      KIND_CREATE  = 5'd17,
      KIND_TABLE   = 5'd18
   } kind_type;

   // scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_IDENT  = 4'b0010,
      MODE_NUMBER = 4'b0100,
      MODE_STRING = 4'b1000
   } mode_type;

   // character codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // keyword spellings, right aligned, and their kinds
   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      48'h53454C454354,   // select
      48'h000046524F4D,   // from
      48'h005748455245,   // where
      48'h494E53455254,   // insert
      48'h0000494E544F,   // into
      48'h56414C554553,   // values
      48'h435245415445,   // create
      48'h005441424C45    // table
   };
   localparam kind_type KW_KIND [KW_COUNT] = '{
      KIND_SELECT, KIND_FROM, KIND_WHERE, KIND_INSERT,
      KIND_INTO, KIND_VALUES, KIND_CREATE, KIND_TABLE
   };

   // channel payloads
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]          token_kind;
      logic [POS_BITS-1:0] start_line;
      logic [POS_BITS-1:0] start_column;
      logic [LEN_BITS-1:0] token_length;
      logic                last_of_run;
   } rsp_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || c == CHAR_UNDER;
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CASE_OFFSET : c;
   endfunction

   function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
      return (v < LEN_MAX) ? v + LEN_BITS'(1) : v;
   endfunction

   // parallel compare against all keywords
   function automatic kind_type ident_kind(input logic [KW_BITS-1:0] chars,
                                           input logic too_long);
      kind_type k;
      k = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (!too_long && chars == KW_TEXT[i]) k = KW_KIND[i];
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sql_token_lexer.sv =====
// ----------------------------------------------------------------------------
// sql_token_lexer
// Byte-serial SQL tokenizer emitting kind, start line, start column and
// length of each token.
// ----------------------------------------------------------------------------
// One text byte is taken per clock unless req_stall is high. Each byte is
// classified and the scanner state updated in the cycle it is accepted; the
// tokens it completes (none, one or two: a byte that ends an identifier or
// number may itself be a token) are written into a four-entry result queue
// that feeds the rsp channel. req_stall rises only while the queue holds more
// than two results, so the block sustains one byte per cycle as long as the
// consumer takes one result per cycle; the rsp port emits at most one result
// per cycle, which is what limits throughput on text dense in two-result
// bytes. A result is queued as its byte is accepted and reaches rsp behind
// any earlier results. An end byte (zero or end_of_text) flushes any pending
// token, emits the end token and returns the scanner to its reset state.
`default_nettype none

module sql_token_lexer
   import stl_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   // scanner state
   mode_type            mode_ff, mode_in;
   logic                quote_double_ff, quote_double_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] column_ff, column_in;
   logic [POS_BITS-1:0] tok_line_ff, tok_line_in;
   logic [POS_BITS-1:0] tok_column_ff, tok_column_in;
   logic [LEN_BITS-1:0] length_ff, length_in;
   logic [KW_BITS-1:0]  kw_chars_ff, kw_chars_in;
   logic                kw_long_ff, kw_long_in;

   // result queue
   rsp_type               queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                accept, pop, is_end, scan;
   logic [7:0]          c;
   logic [7:0]          quote_char;
   logic [POS_BITS-1:0] col_next;
   logic                fin_valid, new_valid;
   kind_type            fin_kind, new_kind;
   logic [LEN_BITS-1:0] new_length;
   rsp_type             fin_rsp, new_rsp, slot_a, slot_b;
   logic [1:0]          push_count;

   assign accept     = req_valid && !req_stall;
   assign pop        = rsp_valid && !rsp_stall;
   assign c          = req_data.text_byte;
   assign is_end     = req_data.end_of_text || c == CHAR_NUL;
   assign col_next   = column_ff + POS_BITS'(1);
   assign quote_char = quote_double_ff ? CHAR_DQUOTE : CHAR_SQUOTE;

   // kind of the pending token being closed
   always_comb begin
      unique case (mode_ff)
         MODE_IDENT:  fin_kind = ident_kind(kw_chars_ff, kw_long_ff);
         MODE_NUMBER: fin_kind = KIND_NUMBER;
         MODE_STRING: fin_kind = KIND_STRING;
         default:     fin_kind = KIND_IDENT;
      endcase
   end

   // byte classification and scanner next state
   always_comb begin
      mode_in         = mode_ff;
      quote_double_in = quote_double_ff;
      line_in         = line_ff;
      column_in       = column_ff;
      tok_line_in     = tok_line_ff;
      tok_column_in   = tok_column_ff;
      length_in       = length_ff;
      kw_chars_in     = kw_chars_ff;
      kw_long_in      = kw_long_ff;
      fin_valid       = 1'b0;
      new_valid       = 1'b0;
      new_kind        = KIND_END;
      new_length      = LEN_BITS'(1);
      scan            = 1'b0;

      if (accept) begin
         column_in = col_next;
         if (is_end) begin
            // flush pending token, then end token, then back to reset state
            fin_valid       = mode_ff != MODE_IDLE;
            new_valid       = 1'b1;
            new_kind        = KIND_END;
            new_length      = '0;
            mode_in         = MODE_IDLE;
            quote_double_in = 1'b0;
            line_in         = POS_BITS'(1);
            column_in       = '0;
            tok_line_in     = '0;
            tok_column_in   = '0;
            length_in       = '0;
            kw_chars_in     = '0;
            kw_long_in      = 1'b0;
         end else begin
            unique case (mode_ff)
               MODE_STRING: begin
                  if (c == quote_char) begin
                     fin_valid = 1'b1;
                     mode_in   = MODE_IDLE;
                  end else begin
                     length_in = sat_inc(length_ff);
                  end
               end
               MODE_IDENT: begin
                  if (is_alpha(c) || is_numeral(c)) begin
                     length_in = sat_inc(length_ff);
                     if (kw_chars_ff[KW_BITS-1 -: 8] != 8'h00) begin
                        kw_long_in = 1'b1;
                     end else if (!kw_long_ff) begin
                        kw_chars_in = {kw_chars_ff[KW_BITS-9:0], to_upper(c)};
                     end
                  end else begin
                     fin_valid = 1'b1;
                     mode_in   = MODE_IDLE;
                     scan      = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_numeral(c)) begin
                     length_in = sat_inc(length_ff);
                  end else begin
                     fin_valid = 1'b1;
                     mode_in   = MODE_IDLE;
                     scan      = 1'b1;
                  end
               end
               default: scan = 1'b1;
            endcase

            // byte scanned as the start of a token
            if (scan) begin
               unique case (c) inside
                  CHAR_SPACE, CHAR_TAB, CHAR_CR: ;
                  CHAR_LF: begin
                     line_in   = line_ff + POS_BITS'(1);
                     column_in = '0;
                  end
                  CHAR_STAR:   begin new_valid = 1'b1; new_kind = KIND_STAR;   end
                  CHAR_COMMA:  begin new_valid = 1'b1; new_kind = KIND_COMMA;  end
                  CHAR_SEMI:   begin new_valid = 1'b1; new_kind = KIND_SEMI;   end
                  CHAR_LPAREN: begin new_valid = 1'b1; new_kind = KIND_LPAREN; end
                  CHAR_RPAREN: begin new_valid = 1'b1; new_kind = KIND_RPAREN; end
                  CHAR_EQUAL:  begin new_valid = 1'b1; new_kind = KIND_EQUAL;  end
                  CHAR_SQUOTE, CHAR_DQUOTE: begin
                     mode_in         = MODE_STRING;
                     quote_double_in = c == CHAR_DQUOTE;
                     tok_line_in     = line_ff;
                     tok_column_in   = col_next;
                     length_in       = '0;
                  end
                  default: begin
                     if (is_alpha(c)) begin
                        mode_in       = MODE_IDENT;
                        tok_line_in   = line_ff;
                        tok_column_in = col_next;
                        length_in     = LEN_BITS'(1);
                        kw_chars_in   = KW_BITS'(to_upper(c));
                        kw_long_in    = 1'b0;
                     end else if (is_numeral(c)) begin
                        mode_in       = MODE_NUMBER;
                        tok_line_in   = line_ff;
                        tok_column_in = col_next;
                        length_in     = LEN_BITS'(1);
                     end else begin
                        new_valid = 1'b1;
                        new_kind  = KIND_ILLEGAL;
                     end
                  end
               endcase
            end
         end
      end
   end

   // result words for this byte
   always_comb begin
      fin_rsp.token_kind   = fin_kind;
      fin_rsp.start_line   = tok_line_ff;
      fin_rsp.start_column = tok_column_ff;
      fin_rsp.token_length = length_ff;
      fin_rsp.last_of_run  = !new_valid;

      new_rsp.token_kind   = new_kind;
      new_rsp.start_line   = line_ff;
      new_rsp.start_column = col_next;
      new_rsp.token_length = new_length;
      new_rsp.last_of_run  = 1'b1;

      slot_a     = fin_valid ? fin_rsp : new_rsp;
      slot_b     = new_rsp;
      push_count = {1'b0, fin_valid} + {1'b0, new_valid};
   end

   // queue pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push_count) - COUNT_BITS'(pop);
   end

   assign req_stall = count_ff > COUNT_BITS'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         quote_double_ff <= 1'b0;
         line_ff         <= POS_BITS'(1);
         column_ff       <= '0;
         tok_line_ff     <= '0;
         tok_column_ff   <= '0;
         length_ff       <= '0;
         kw_chars_ff     <= '0;
         kw_long_ff      <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         mode_ff         <= mode_in;
         quote_double_ff <= quote_double_in;
         line_ff         <= line_in;
         column_ff       <= column_in;
         tok_line_ff     <= tok_line_in;
         tok_column_ff   <= tok_column_in;
         length_ff       <= length_in;
         kw_chars_ff     <= kw_chars_in;
         kw_long_ff      <= kw_long_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   // queue storage, up to two writes per transfer
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot_a;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_BITS'(1)] <= slot_b;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/stl_chk.sv =====
// ----------------------------------------------------------------------------
// stl_chk
// Port-level checks for the SQL token lexer, bound into the lexer module.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_chk
   import stl_pkg::*;
(
   input wire     clock,
   input wire     reset,
   input wire     req_stall,
   input wire     rsp_valid,
   input wire     rsp_stall,
   input rsp_type rsp_data
);

   // no result and room for input right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending or input stalled after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // end token is empty and closes its run
   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == KIND_END |->
         rsp_data.token_length == '0 && rsp_data.last_of_run)
      else $error("malformed end token");

   // single-character tokens have length one
   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind <= KIND_EQUAL ||
                    rsp_data.token_kind == KIND_ILLEGAL) |->
         rsp_data.token_length == LEN_BITS'(1) && rsp_data.last_of_run)
      else $error("punctuation or illegal token with wrong length");

   // keywords are at most six characters long
   a_keyword_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind >= KIND_SELECT |->
         rsp_data.token_length <= LEN_BITS'(KW_CHARS) &&
         rsp_data.token_length != '0)
      else $error("keyword with impossible length");

endmodule

bind sql_token_lexer stl_chk u_stl_chk (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
